/* rtl/integer_to_ascii_formatter_defines.svh */
// Assertion macros for the checker file of the integer-to-ASCII formatter.
// No dependencies; include with the bare file name.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define ITAF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itaf assertion failed");

// Next-cycle implication, disabled while in reset
`define ITAF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itaf assertion failed");

`endif

/* rtl/itaf_pkg.sv */
// Package for the integer-to-ASCII formatter: command codes, character constants,
// digit-to-ASCII function and the sequencer state type. No dependencies.
package itaf_pkg;

	localparam logic [1:0] CMD_SDEC = 2'd0;
	localparam logic [1:0] CMD_UDEC = 2'd1;
	localparam logic [1:0] CMD_HEXU = 2'd2;
	localparam logic [1:0] CMD_HEXL = 2'd3;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_UPPER  = 8'h41 - 8'd10;
	localparam logic [7:0] CH_LOWER  = 8'h61 - 8'd10;

	localparam int NIBBLES   = 16;
	localparam int DEC_DIGITS = 10;
	localparam int BIN_BITS  = 32;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CONV  = 4'b0010,
		ST_STRIP = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	function automatic logic [7:0] digit_ascii(input logic [3:0] nib, input logic lower);
		logic [7:0] base;
		if (nib < 4'd10)
			base = CH_ZERO;
		else if (lower)
			base = CH_LOWER;
		else
			base = CH_UPPER;
		return base + {4'd0, nib};
	endfunction

endpackage

/* rtl/integer_to_ascii_formatter.sv */
// Integer-to-ASCII formatter: signed/unsigned decimal and 64-bit hex text, one char per item.
// Decimal runs 32 shift-add steps, then one strip step per leading zero digit plus one, then
// emits the chars; hex runs only the strip steps, then emits. A '-' char comes first if negative.
// Input is taken only while idle; the output register lets the next number in while the last
// char waits. Reset: arst_n async active low, clears sequencer and output valid. Uses itaf_pkg.
module integer_to_ascii_formatter
	import itaf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [63:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic        is_last,
	output logic [4:0]  char_count
);

	state_t      state_q;
	logic [63:0] dig_q;     // digit window, most significant nibble on top
	logic [31:0] bin_q;     // binary shifted into BCD
	logic [4:0]  bit_q;
	logic [4:0]  ndig_q;    // digits left in window
	logic [4:0]  cnt_q;
	logic        neg_q;
	logic        lower_q;
	logic        out_valid_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic [4:0]  count_q;

	logic [39:0] bcd_adj;
	logic [31:0] low_w;
	logic [31:0] mag_w;
	logic        take_in;
	logic        out_free;

	assign low_w   = value[31:0];
	assign mag_w   = (command == CMD_SDEC && low_w[31]) ? (~low_w + 32'd1) : low_w;
	assign in_stall = (state_q != ST_IDLE);
	assign take_in = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// add-3 correction on every BCD digit
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			bcd_adj[i*4 +: 4] = (dig_q[24 + i*4 +: 4] >= 4'd5) ?
				dig_q[24 + i*4 +: 4] + 4'd3 : dig_q[24 + i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dig_q       <= '0;
			bin_q       <= '0;
			bit_q       <= '0;
			ndig_q      <= '0;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			lower_q     <= 1'b0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
			count_q     <= '0;
		end else begin
			// output slot free: it holds the next char if one is emitted, else empties
			if (out_free)
				out_valid_q <= (state_q == ST_EMIT);
			unique case (state_q)
				ST_IDLE: begin
					if (take_in) begin
						cnt_q   <= '0;
						lower_q <= (command == CMD_HEXL);
						if (command == CMD_HEXU || command == CMD_HEXL) begin
							dig_q   <= value;
							ndig_q  <= 5'(NIBBLES);
							neg_q   <= 1'b0;
							state_q <= ST_STRIP;
						end else begin
							dig_q   <= '0;
							bin_q   <= mag_w;
							bit_q   <= '0;
							ndig_q  <= 5'(DEC_DIGITS);
							neg_q   <= (command == CMD_SDEC) && low_w[31];
							state_q <= ST_CONV;
						end
					end
				end
				ST_CONV: begin
					dig_q[63:24] <= {bcd_adj[38:0], bin_q[31]};
					bin_q        <= {bin_q[30:0], 1'b0};
					bit_q        <= bit_q + 5'd1;
					if (bit_q == 5'(BIN_BITS - 1))
						state_q <= ST_STRIP;
				end
				ST_STRIP: begin
					if (ndig_q > 5'd1 && dig_q[63:60] == 4'd0) begin
						dig_q  <= {dig_q[59:0], 4'd0};
						ndig_q <= ndig_q - 5'd1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						cnt_q       <= cnt_q + 5'd1;
						count_q     <= cnt_q + 5'd1;
						if (neg_q) begin
							char_q <= CH_MINUS;
							last_q <= 1'b0;
							neg_q  <= 1'b0;
						end else begin
							char_q <= digit_ascii(dig_q[63:60], lower_q);
							last_q <= (ndig_q == 5'd1);
							dig_q  <= {dig_q[59:0], 4'd0};
							ndig_q <= ndig_q - 5'd1;
							if (ndig_q == 5'd1)
								state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign is_last    = last_q;
	assign char_count = count_q;

endmodule

/* rtl/itaf_checker.sv */
// Port-level checker for the integer-to-ASCII formatter, bound to the top level.
// Depends on integer_to_ascii_formatter_defines.svh.
`include "integer_to_ascii_formatter_defines.svh"
module itaf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  command,
	input logic [63:0] value,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  character,
	input logic        is_last,
	input logic [4:0]  char_count
);

	`ITAF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(character) && $stable(char_count) && $stable(is_last))
	`ITAF_ASSERT_SAME(a_count_range, out_valid, char_count >= 5'd1 && char_count <= 5'd16)
	`ITAF_ASSERT_NEXT(a_count_step, out_valid && !out_stall && !is_last, out_valid && char_count == $past(char_count) + 5'd1)
	`ITAF_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (.*);
